/* rtl/core/mvp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvp_pkg
// Shared types, sizes and helpers of the matrix-vector product block.
// ----------------------------------------------------------------------------
package mvp_pkg;

    localparam int MAX_DIM   = 8;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int DIM_W     = $clog2(MAX_DIM + 1);
    localparam int MADDR_W   = 2 * IDX_W;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W     = 4;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = PROD_W + $clog2(MAX_DIM) + 1;
    localparam int FRAC_W    = 16;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = CFG_IDX_W'(1);

    localparam logic CMD_MATRIX_WRITE = 1'b0;
    localparam logic CMD_VECTOR_ELEM  = 1'b1;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_LEN_ERR  = 1'b1;

    typedef struct packed {
        logic                     cmd;
        logic [2:0]               row_index;
        logic [2:0]               col_index;
        logic signed [DATA_W-1:0] element_value;
        logic                     last_element;
    } t_mvp_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic [2:0]               result_row;
        logic                     last_result;
        logic                     status;
        logic                     saturated;
    } t_mvp_out;

    typedef struct packed {
        logic             first_col;
        logic             last_col;
        logic             last_row;
        logic [IDX_W-1:0] row;
    } t_mvp_tag;

    // zero acts as one, anything above the array size acts as the array size
    function automatic logic [DIM_W-1:0] mvp_effective(input logic [CFG_W-1:0] reg_val);
        logic [DIM_W-1:0] eff;
        if (reg_val == '0) begin
            eff = DIM_W'(1);
        end else if (reg_val > CFG_W'(MAX_DIM)) begin
            eff = DIM_W'(MAX_DIM);
        end else begin
            eff = DIM_W'(reg_val);
        end
        return eff;
    endfunction

endpackage

/* rtl/core/matrix_vector_product_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_vector_product_top
// Signed Q16.16 matrix-vector product over a stored matrix.
//
//  channel   direction  handshake                       payload
//  item      in         start && !busy                  i_item (t_mvp_in)
//  result    out        o_result_valid, one-cycle strobe o_result (t_mvp_out)
//  config    in         i_cfg_valid && o_cfg_ready      i_cfg_index, i_cfg_data
//
// matrix writes and non-final vector elements are taken without raising busy.
// a final vector element with matching length raises busy until the last row
// result, one MAC per cycle from the matrix memory read port; each row result
// passes the read, multiply, accumulate and output registers to the ports.
// a length error gives its single result the cycle after transfer, no busy.
// results cannot be stalled; reset clears control state, memories are not cleared.
// ----------------------------------------------------------------------------
module matrix_vector_product_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  mvp_pkg::t_mvp_in                i_item,
    output logic                            o_result_valid,
    output mvp_pkg::t_mvp_out               o_result,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mvp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mvp_pkg::CFG_W-1:0]       i_cfg_data
);
    import mvp_pkg::*;

    logic signed [DATA_W-1:0] matrix_mem [MAX_DIM*MAX_DIM];
    logic signed [DATA_W-1:0] vector_mem [MAX_DIM];

    logic [CFG_W-1:0]  r_rows_cfg;
    logic [CFG_W-1:0]  r_cols_cfg;
    logic [CNT_W-1:0]  r_vcount;
    logic [CNT_W-1:0]  n_vcount;
    logic              r_busy;

    logic [DIM_W-1:0]  r_rows;
    logic [DIM_W-1:0]  r_cols;
    logic              r_issue;
    logic [IDX_W-1:0]  r_row;
    logic [IDX_W-1:0]  r_col;

    logic                     r_rd_valid;
    t_mvp_tag                 r_rd_tag;
    logic signed [DATA_W-1:0] r_m_rdata;
    logic signed [DATA_W-1:0] r_v_rdata;

    logic                     r_mul_valid;
    t_mvp_tag                 r_mul_tag;
    logic signed [PROD_W-1:0] r_prod;

    logic                     r_acc_done;
    t_mvp_tag                 r_acc_tag;
    logic signed [ACC_W-1:0]  r_acc;

    logic     r_out_valid;
    t_mvp_out r_out;

    logic             accept;
    logic             vec_accept;
    logic             issue_last_col;
    logic             issue_last_row;
    logic [DIM_W-1:0] eff_rows;
    logic [DIM_W-1:0] eff_cols;
    logic             acc_in_range;
    t_mvp_tag         issue_tag;

    assign accept     = start && !r_busy;
    assign vec_accept = accept && (i_item.cmd == CMD_VECTOR_ELEM);
    assign eff_rows   = mvp_effective(r_rows_cfg);
    assign eff_cols   = mvp_effective(r_cols_cfg);
    assign n_vcount   = (r_vcount < CNT_MAX) ? r_vcount + CNT_W'(1) : r_vcount;

    assign issue_last_col = (DIM_W'(r_col) == r_cols - DIM_W'(1));
    assign issue_last_row = (DIM_W'(r_row) == r_rows - DIM_W'(1));
    assign issue_tag = '{first_col: (r_col == '0), last_col: issue_last_col,
                         last_row: issue_last_row, row: r_row};

    assign acc_in_range = (&r_acc[ACC_W-1:FRAC_W+DATA_W-1]) ||
                          (~|r_acc[ACC_W-1:FRAC_W+DATA_W-1]);

    // memories
    always_ff @(posedge i_clk) begin
        if (accept && i_item.cmd == CMD_MATRIX_WRITE) begin
            matrix_mem[{i_item.row_index[IDX_W-1:0], i_item.col_index[IDX_W-1:0]}]
                <= i_item.element_value;
        end
        if (vec_accept && r_vcount < CNT_W'(MAX_DIM)) begin
            vector_mem[r_vcount[IDX_W-1:0]] <= i_item.element_value;
        end
        r_m_rdata <= matrix_mem[{r_row, r_col}];
        r_v_rdata <= vector_mem[r_col];
    end

    // config, vector count and issue sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= CFG_W'(MAX_DIM);
            r_cols_cfg <= CFG_W'(MAX_DIM);
            r_vcount   <= '0;
            r_busy     <= 1'b0;
            r_issue    <= 1'b0;
            r_row      <= '0;
            r_col      <= '0;
            r_rows     <= DIM_W'(1);
            r_cols     <= DIM_W'(1);
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ROWS_IN_USE: r_rows_cfg <= i_cfg_data;
                    CFG_COLS_IN_USE: r_cols_cfg <= i_cfg_data;
                    default: ;
                endcase
            end
            if (vec_accept) begin
                if (i_item.last_element) begin
                    r_vcount <= '0;
                    if (n_vcount == CNT_W'(eff_cols)) begin
                        r_busy  <= 1'b1;
                        r_issue <= 1'b1;
                        r_row   <= '0;
                        r_col   <= '0;
                        r_rows  <= eff_rows;
                        r_cols  <= eff_cols;
                    end
                end else begin
                    r_vcount <= n_vcount;
                end
            end
            if (r_issue) begin
                if (issue_last_col) begin
                    r_col <= '0;
                    if (issue_last_row) begin
                        r_issue <= 1'b0;
                    end else begin
                        r_row <= r_row + IDX_W'(1);
                    end
                end else begin
                    r_col <= r_col + IDX_W'(1);
                end
            end
            if (r_acc_done && r_acc_tag.last_row) begin
                r_busy <= 1'b0;
            end
        end
    end

    // read, multiply, accumulate and result stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid  <= 1'b0;
            r_mul_valid <= 1'b0;
            r_acc_done  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_valid  <= r_issue;
            r_mul_valid <= r_rd_valid;
            r_acc_done  <= r_mul_valid && r_mul_tag.last_col;
            r_out_valid <= r_acc_done ||
                           (vec_accept && i_item.last_element &&
                            n_vcount != CNT_W'(eff_cols));
        end
        r_rd_tag  <= issue_tag;
        r_mul_tag <= r_rd_tag;
        r_prod    <= r_m_rdata * r_v_rdata;
        if (r_mul_valid) begin
            r_acc_tag <= r_mul_tag;
            if (r_mul_tag.first_col) begin
                r_acc <= ACC_W'(r_prod);
            end else begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
        if (r_acc_done) begin
            r_out.result_row  <= 3'(r_acc_tag.row);
            r_out.last_result <= r_acc_tag.last_row;
            r_out.status      <= STATUS_OK;
            r_out.saturated   <= !acc_in_range;
            if (acc_in_range) begin
                r_out.result_value <= r_acc[FRAC_W +: DATA_W];
            end else if (r_acc[ACC_W-1]) begin
                r_out.result_value <= {1'b1, {(DATA_W-1){1'b0}}};
            end else begin
                r_out.result_value <= {1'b0, {(DATA_W-1){1'b1}}};
            end
        end else begin
            r_out.result_value <= '0;
            r_out.result_row   <= '0;
            r_out.last_result  <= 1'b1;
            r_out.status       <= STATUS_LEN_ERR;
            r_out.saturated    <= 1'b0;
        end
    end

    assign busy           = r_busy;
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;
    assign o_cfg_ready    = 1'b1;

    a_busy_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> $past(vec_accept && i_item.last_element))
        else $error("busy rose without a final vector element");

    a_issue_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issue |-> r_busy)
        else $error("issue active while not busy");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last_result) |-> !r_busy)
        else $error("busy still high on final result");

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == STATUS_LEN_ERR) |->
            (r_out.result_row == '0 && !r_out.saturated && r_out.last_result))
        else $error("malformed length error result");

endmodule

/* dv/mvp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvp_checker
// Passive checker for the matrix-vector product block. It watches the item,
// configuration and result channels and keeps its own copy of the matrix,
// the streamed vector and the dimension registers. On every final vector
// element it predicts the row results (exact wide sum, truncation to Q16.16,
// saturation) or the single length error. Each result strobe is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module mvp_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  mvp_pkg::t_mvp_in              i_item,
    input  logic                          i_result_valid,
    input  mvp_pkg::t_mvp_out             i_result,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [mvp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mvp_pkg::CFG_W-1:0]     i_cfg_data,
    output int                            o_pending,
    output int                            o_fail_count
);
    import mvp_pkg::*;

    localparam int SUM_W = 80;
    localparam logic signed [SUM_W-1:0] Q_MAX = (80'sd1 <<< 31) - 80'sd1;
    localparam logic signed [SUM_W-1:0] Q_MIN = -(80'sd1 <<< 31);

    logic [DATA_W-1:0] matrix_copy [MAX_DIM][MAX_DIM];
    logic [DATA_W-1:0] vector_copy [MAX_DIM];
    logic [CNT_W-1:0]  vector_len;
    logic [CFG_W-1:0]  rows_reg;
    logic [CFG_W-1:0]  cols_reg;
    t_mvp_out          row_results_q [$];
    int                waiting    = 0;
    int                mismatches = 0;

    assign o_pending    = waiting;
    assign o_fail_count = mismatches;

    function automatic int dim_in_use(input logic [CFG_W-1:0] setting);
        if (setting == '0) begin
            return 1;
        end
        if (setting > CFG_W'(MAX_DIM)) begin
            return MAX_DIM;
        end
        return int'(setting);
    endfunction

    function automatic t_mvp_out row_dot(input int row, input int ncols);
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] a;
        logic signed [SUM_W-1:0] b;
        logic signed [SUM_W-1:0] scaled;
        t_mvp_out                res;
        sum = '0;
        for (int c = 0; c < ncols; c++) begin
            a   = $signed(matrix_copy[row][c]);
            b   = $signed(vector_copy[c]);
            sum = sum + a * b;
        end
        scaled         = sum >>> FRAC_W;
        res            = '0;
        res.result_row = 3'(row);
        res.status     = STATUS_OK;
        if (scaled > Q_MAX) begin
            res.result_value = 32'h7FFF_FFFF;
            res.saturated    = 1'b1;
        end else if (scaled < Q_MIN) begin
            res.result_value = 32'h8000_0000;
            res.saturated    = 1'b1;
        end else begin
            res.result_value = scaled[DATA_W-1:0];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_mvp_out want;
        int       nrows;
        int       ncols;
        if (!i_rst_n) begin
            row_results_q.delete();
            vector_len = '0;
            rows_reg   = CFG_W'(MAX_DIM);
            cols_reg   = CFG_W'(MAX_DIM);
        end else begin
            if (i_result_valid) begin
                if (row_results_q.size() == 0) begin
                    $error("unexpected result: row %0d value %h status %b",
                           i_result.result_row, i_result.result_value, i_result.status);
                    mismatches++;
                end else begin
                    want = row_results_q.pop_front();
                    if (i_result.result_value !== want.result_value) begin
                        $error("result_value: expected %h, actual %h",
                               want.result_value, i_result.result_value);
                        mismatches++;
                    end
                    if (i_result.result_row !== want.result_row) begin
                        $error("result_row: expected %0d, actual %0d",
                               want.result_row, i_result.result_row);
                        mismatches++;
                    end
                    if (i_result.last_result !== want.last_result) begin
                        $error("last_result: expected %b, actual %b",
                               want.last_result, i_result.last_result);
                        mismatches++;
                    end
                    if (i_result.status !== want.status) begin
                        $error("status: expected %b, actual %b", want.status, i_result.status);
                        mismatches++;
                    end
                    if (i_result.saturated !== want.saturated) begin
                        $error("saturated: expected %b, actual %b",
                               want.saturated, i_result.saturated);
                        mismatches++;
                    end
                end
            end

            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_ROWS_IN_USE) begin
                    rows_reg = i_cfg_data;
                end else if (i_cfg_index == CFG_COLS_IN_USE) begin
                    cols_reg = i_cfg_data;
                end
            end

            if (i_start && !i_busy) begin
                if (i_item.cmd == CMD_MATRIX_WRITE) begin
                    matrix_copy[i_item.row_index][i_item.col_index] = i_item.element_value;
                end else begin
                    if (vector_len < CNT_W'(MAX_DIM)) begin
                        vector_copy[vector_len] = i_item.element_value;
                    end
                    if (vector_len != CNT_MAX) begin
                        vector_len++;
                    end
                    if (i_item.last_element) begin
                        nrows = dim_in_use(rows_reg);
                        ncols = dim_in_use(cols_reg);
                        if (int'(vector_len) != ncols) begin
                            want             = '0;
                            want.last_result = 1'b1;
                            want.status      = STATUS_LEN_ERR;
                            row_results_q.push_back(want);
                        end else begin
                            for (int r = 0; r < nrows; r++) begin
                                want             = row_dot(r, ncols);
                                want.last_result = (r == nrows - 1);
                                row_results_q.push_back(want);
                            end
                        end
                        vector_len = '0;
                    end
                end
            end
        end
        waiting = row_results_q.size();
    end

endmodule

/* dv/tb_matrix_vector_product_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_vector_product_top
// Stimulus and verdict for the matrix-vector product block. The matrix is
// filled completely first, then directed vectors hit saturation in both
// directions, length errors, an overlong vector, a matrix write carrying the
// last flag and out-of-range dimension settings. Random phases follow with
// new dimensions, mostly well-formed vectors with random content, some
// matrix writes mixed in and some vectors of the wrong length. The sender
// idles in random bursts; the last part runs back to back.
// ----------------------------------------------------------------------------
module tb_matrix_vector_product_top;
    import mvp_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_mvp_in              i_item;
    logic                 o_result_valid;
    t_mvp_out             o_result;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    int                   pending;
    int                   fail_count;
    int                   items_sent;
    bit                   idle_on;

    matrix_vector_product_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    mvp_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_item         (i_item),
        .i_result_valid (o_result_valid),
        .i_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_pending      (pending),
        .o_fail_count   (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_mvp_in matrix_write(input logic [2:0] r, input logic [2:0] c,
                                             input logic [DATA_W-1:0] v, input logic flag);
        t_mvp_in it;
        it.cmd           = CMD_MATRIX_WRITE;
        it.row_index     = r;
        it.col_index     = c;
        it.element_value = v;
        it.last_element  = flag;
        return it;
    endfunction

    task automatic send_item(input t_mvp_in it);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge i_clk);
        end
        @(negedge i_clk);
        start  = 1'b1;
        i_item = it;
        do begin
            @(posedge i_clk);
        end while (busy);
        items_sent++;
    endtask

    // vector of n elements, last flag on the final one
    task automatic send_vector(input int n, input bit use_fixed, input logic [DATA_W-1:0] fixed);
        t_mvp_in it;
        for (int i = 0; i < n; i++) begin
            if (!use_fixed && $urandom_range(0, 9) == 0) begin
                send_item(matrix_write(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                                       pick_value(), 1'($urandom_range(0, 1))));
            end
            it.cmd           = CMD_VECTOR_ELEM;
            it.row_index     = 3'($urandom_range(0, 7));
            it.col_index     = 3'($urandom_range(0, 7));
            it.element_value = use_fixed ? fixed : pick_value();
            it.last_element  = (i == n - 1);
            send_item(it);
        end
    endtask

    // stop sending and let every expected result arrive
    task automatic settle();
        @(negedge i_clk);
        start = 1'b0;
        wait (pending == 0);
        repeat (4) @(negedge i_clk);
        while (busy) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_dims(input logic [CFG_W-1:0] nrows, input logic [CFG_W-1:0] ncols);
        settle();
        write_reg(CFG_ROWS_IN_USE, nrows);
        write_reg(CFG_COLS_IN_USE, ncols);
    endtask

    initial begin
        logic [DATA_W-1:0] v;
        logic [CFG_W-1:0]  nrows;
        logic [CFG_W-1:0]  ncols;
        int                cols_eff;
        int                kind;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        items_sent  = 0;
        idle_on     = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // whole matrix written first: max row, min row, zero row, alternating row
        for (int r = 0; r < MAX_DIM; r++) begin
            for (int c = 0; c < MAX_DIM; c++) begin
                case (r)
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0000_0000;
                    3: v = c[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
                    default: v = pick_value();
                endcase
                send_item(matrix_write(3'(r), 3'(c), v, 1'b0));
            end
        end

        set_dims(4'd8, 4'd2);
        send_vector(2, 1'b1, 32'h7FFF_FFFF);
        send_vector(2, 1'b1, 32'h8000_0000);
        send_item(matrix_write(3'd2, 3'd0, 32'h0001_0000, 1'b1));
        send_vector(1, 1'b1, 32'h0001_0000);
        set_dims(4'd0, 4'd0);
        send_vector(1, 1'b1, 32'h0002_0000);
        send_vector(2, 1'b1, 32'hFFFF_FFFF);
        set_dims(4'd9, 4'd15);
        send_vector(8, 1'b1, 32'hFFFF_0000);
        send_vector(9, 1'b1, 32'h0000_0001);

        while (items_sent < 430) begin
            idle_on = (items_sent < 380) && ($urandom_range(0, 3) != 0);
            nrows   = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(1, 8));
            ncols   = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(1, 8));
            set_dims(nrows, ncols);
            cols_eff = (ncols == 0) ? 1 : ((ncols > MAX_DIM) ? MAX_DIM : int'(ncols));
            repeat ($urandom_range(3, 8)) begin
                repeat ($urandom_range(0, 3)) begin
                    send_item(matrix_write(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                                           pick_value(), 1'($urandom_range(0, 1))));
                end
                kind = $urandom_range(0, 9);
                if (kind == 8) begin
                    send_vector($urandom_range(1, 17), 1'b0, '0);
                end else begin
                    if (kind == 9 && items_sent < 380) begin
                        settle();
                    end
                    send_vector(cols_eff, 1'b0, '0);
                end
            end
        end

        settle();
        repeat (80) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
